### src/afvg_pkg.sv
// Shared types, widths, constants and helper functions of the arc fan vertex generator.
package afvg_pkg;

    // Sizing of the fixed fields
    localparam int INDEX_W       = 9;
    localparam int SIDES_W       = 8;
    localparam int RADIUS_W      = 15;
    localparam int ANGLE_W       = 16;
    localparam int CENTER_W      = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_ADDR_W    = 3;

    // Tunable sizing
    localparam int MAX_SIDES     = 255;
    localparam int CORDIC_STAGES = 14;
    localparam int COORD_WIDTH   = 16;

    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    localparam int IN_TDATA_W    = ((INDEX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((2 * COORD_WIDTH + 7) / 8) * 8;

    // Interpolation: diff * (k-1), then divide by the segment count
    localparam int DIFF_W        = ANGLE_W + 1;
    localparam int NUM_W         = DIFF_W + SIDES_W;
    localparam int DIV_STEPS     = 5;
    localparam int DIV_STAGES    = NUM_W / DIV_STEPS;

    // Angle in Q2.30
    localparam int FRAC_Q30      = 30;
    localparam int Q30_SHIFT     = FRAC_Q30 - 12;
    localparam int RED_W         = ANGLE_W + Q30_SHIFT + 1;
    localparam int Z_W           = 32;
    localparam int TRIG_W        = 32;

    localparam logic signed [RED_W-1:0] PI_Q30      = RED_W'(64'sd3373259426);
    localparam logic signed [RED_W-1:0] NEG_PI_Q30  = RED_W'(-64'sd3373259426);
    localparam logic signed [RED_W-1:0] TWO_PI_Q30  = RED_W'(64'sd6746518852);
    localparam logic signed [RED_W-1:0] HALF_PI_Q30 = RED_W'(64'sd1686629713);
    localparam logic signed [RED_W-1:0] NEG_HALF_PI_Q30 = RED_W'(-64'sd1686629713);
    localparam logic signed [TRIG_W-1:0] GAIN_Q30   = TRIG_W'(64'sd652032875);

    // Scaling: radius * trig, rounded back to Q1.14
    localparam int PROD_W        = RADIUS_W + 1 + TRIG_W;
    localparam int SCALED_W      = PROD_W - FRAC_Q30;
    localparam int SUM_W         = ((SCALED_W > COORD_WIDTH) ? SCALED_W : COORD_WIDTH) + 2;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_Q30 - 1));
    localparam logic signed [SUM_W-1:0] COORD_MAX =
        SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] COORD_MIN = SUM_W'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ARC_SIDES   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_ANGLE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END_ANGLE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y    = 3'd5;

    typedef enum logic [1:0] {
        KIND_ARC,
        KIND_CENTER,
        KIND_INVALID
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  last;
    } meta_t;

    typedef struct packed {
        logic        [RADIUS_W-1:0] radius;
        logic signed [ANGLE_W-1:0]  start_angle;
        logic signed [ANGLE_W-1:0]  end_angle;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
    } cfg_t;

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 32'sd843314857;
            1:       v = 32'sd497837829;
            2:       v = 32'sd263043837;
            3:       v = 32'sd133525159;
            4:       v = 32'sd67021687;
            5:       v = 32'sd33543516;
            6:       v = 32'sd16775851;
            7:       v = 32'sd8388437;
            8:       v = 32'sd4194283;
            9:       v = 32'sd2097149;
            10:      v = 32'sd1048576;
            11:      v = 32'sd524288;
            12:      v = 32'sd262144;
            13:      v = 32'sd131072;
            14:      v = 32'sd65536;
            15:      v = 32'sd32768;
            16:      v = 32'sd16384;
            17:      v = 32'sd8192;
            18:      v = 32'sd4096;
            19:      v = 32'sd2048;
            20:      v = 32'sd1024;
            21:      v = 32'sd512;
            22:      v = 32'sd256;
            23:      v = 32'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > COORD_MAX) begin
            c = COORD_MAX;
        end else if (v < COORD_MIN) begin
            c = COORD_MIN;
        end else begin
            c = v;
        end
        return COORD_WIDTH'(c);
    endfunction

endpackage

### src/afvg_front.sv
// Index decode and angle-difference multiply: first two pipeline stages.
module afvg_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  afvg_pkg::cfg_t                cfg,
    input  logic [afvg_pkg::SIDES_W-1:0]  sides,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [afvg_pkg::INDEX_W-1:0]  in_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output afvg_pkg::meta_t               out_meta,
    output logic                          out_neg,
    output logic [afvg_pkg::NUM_W-1:0]    out_mag
);
    import afvg_pkg::*;

    logic                 s1_valid_reg, s2_valid_reg;
    logic                 s1_rdy, s2_rdy;
    meta_t                s1_meta_reg, s1_meta_next, s2_meta_reg;
    logic [SIDES_W-1:0]   s1_km1_reg, s1_km1_next;
    logic                 s2_neg_reg, s2_neg_next;
    logic [NUM_W-1:0]     s2_mag_reg, s2_mag_next;

    logic [INDEX_W:0]     lim;
    logic [INDEX_W:0]     idx_ext;
    logic signed [DIFF_W-1:0] diff;
    logic signed [NUM_W:0]    num;

    assign s2_rdy   = !s2_valid_reg || out_ready;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // Stage 1: classify the index
    assign lim     = (INDEX_W + 1)'(sides) + (INDEX_W + 1)'(1);
    assign idx_ext = {1'b0, in_index};

    always_comb begin
        s1_meta_next.last = 1'b0;
        if (in_index == '0) begin
            s1_meta_next.kind = KIND_CENTER;
        end else if (idx_ext > lim) begin
            s1_meta_next.kind = KIND_INVALID;
        end else begin
            s1_meta_next.kind = KIND_ARC;
            s1_meta_next.last = (idx_ext == lim);
        end
        s1_km1_next = SIDES_W'(in_index - INDEX_W'(1));
    end

    // Stage 2: diff * (k-1), split into sign and magnitude
    assign diff = $signed({cfg.end_angle[ANGLE_W-1], cfg.end_angle})
                - $signed({cfg.start_angle[ANGLE_W-1], cfg.start_angle});
    assign num  = diff * $signed({1'b0, s1_km1_reg});

    always_comb begin
        s2_neg_next = num[NUM_W];
        s2_mag_next = s2_neg_next ? NUM_W'(-num) : NUM_W'(num);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_rdy) s1_valid_reg <= in_valid;
            if (s2_rdy) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy) begin
            s1_meta_reg <= s1_meta_next;
            s1_km1_reg  <= s1_km1_next;
        end
        if (s2_rdy) begin
            s2_meta_reg <= s1_meta_reg;
            s2_neg_reg  <= s2_neg_next;
            s2_mag_reg  <= s2_mag_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_meta  = s2_meta_reg;
    assign out_neg   = s2_neg_reg;
    assign out_mag   = s2_mag_reg;

endmodule

### src/afvg_div.sv
// Pipelined restoring divider: magnitude over segment count, DIV_STEPS quotient bits per stage.
module afvg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [afvg_pkg::SIDES_W-1:0]  divisor,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  afvg_pkg::meta_t               in_meta,
    input  logic                          in_neg,
    input  logic [afvg_pkg::NUM_W-1:0]    in_mag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output afvg_pkg::meta_t               out_meta,
    output logic                          out_neg,
    output logic [afvg_pkg::NUM_W-1:0]    out_quot
);
    import afvg_pkg::*;

    logic               v_reg    [DIV_STAGES];
    logic               rdy      [DIV_STAGES];
    meta_t              meta_reg [DIV_STAGES];
    logic               neg_reg  [DIV_STAGES];
    logic [SIDES_W-1:0] rem_reg  [DIV_STAGES];
    logic [NUM_W-1:0]   num_reg  [DIV_STAGES];
    logic [NUM_W-1:0]   quot_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic               src_v;
        meta_t              src_meta;
        logic               src_neg;
        logic [SIDES_W-1:0] src_rem, rem_next;
        logic [NUM_W-1:0]   src_num, num_next;
        logic [NUM_W-1:0]   src_quot, quot_next;

        if (g == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_meta = in_meta;
            assign src_neg  = in_neg;
            assign src_rem  = '0;
            assign src_num  = in_mag;
            assign src_quot = '0;
        end else begin : g_rest
            assign src_v    = v_reg[g-1];
            assign src_meta = meta_reg[g-1];
            assign src_neg  = neg_reg[g-1];
            assign src_rem  = rem_reg[g-1];
            assign src_num  = num_reg[g-1];
            assign src_quot = quot_reg[g-1];
        end

        if (g == DIV_STAGES - 1) begin : g_tail
            assign rdy[g] = !v_reg[g] || out_ready;
        end else begin : g_body
            assign rdy[g] = !v_reg[g] || rdy[g+1];
        end

        // Shift in one dividend bit per step, subtract where it fits
        always_comb begin : p_steps
            logic [SIDES_W:0] trial;
            rem_next  = src_rem;
            num_next  = src_num;
            quot_next = src_quot;
            for (int s = 0; s < DIV_STEPS; s++) begin
                trial    = {rem_next, num_next[NUM_W-1]};
                num_next = num_next << 1;
                if (trial >= {1'b0, divisor}) begin
                    rem_next  = SIDES_W'(trial - {1'b0, divisor});
                    quot_next = {quot_next[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next  = trial[SIDES_W-1:0];
                    quot_next = {quot_next[NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                v_reg[g] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g]) begin
                meta_reg[g] <= src_meta;
                neg_reg[g]  <= src_neg;
                rem_reg[g]  <= rem_next;
                num_reg[g]  <= num_next;
                quot_reg[g] <= quot_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_meta  = meta_reg[DIV_STAGES-1];
    assign out_neg   = neg_reg[DIV_STAGES-1];
    assign out_quot  = quot_reg[DIV_STAGES-1];

endmodule

### src/afvg_angle.sv
// Angle assembly, range reduction to [-pi, pi] and fold into [-pi/2, pi/2].
module afvg_angle (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  afvg_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  afvg_pkg::meta_t               in_meta,
    input  logic                          in_neg,
    input  logic [afvg_pkg::NUM_W-1:0]    in_quot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output afvg_pkg::meta_t               out_meta,
    output logic                          out_flip,
    output logic signed [afvg_pkg::Z_W-1:0] out_z
);
    import afvg_pkg::*;

    logic                     a_valid_reg, r_valid_reg, f_valid_reg;
    logic                     a_rdy, r_rdy, f_rdy;
    meta_t                    a_meta_reg, r_meta_reg, f_meta_reg;
    logic signed [ANGLE_W-1:0] ang_reg, ang_next;
    logic signed [RED_W-1:0]  red_reg, red_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     flip_reg, flip_next;

    logic signed [ANGLE_W+1:0] qs;
    logic signed [ANGLE_W+1:0] ang_wide;
    logic signed [RED_W-1:0]   a_q30;
    logic signed [RED_W-1:0]   fold;

    assign f_rdy    = !f_valid_reg || out_ready;
    assign r_rdy    = !r_valid_reg || f_rdy;
    assign a_rdy    = !a_valid_reg || r_rdy;
    assign in_ready = a_rdy;

    // Start angle plus signed quotient; the sum stays between start and end
    assign qs       = $signed({1'b0, in_quot[ANGLE_W:0]});
    assign ang_wide = $signed({{2{cfg.start_angle[ANGLE_W-1]}}, cfg.start_angle})
                    + (in_neg ? -qs : qs);
    assign ang_next = ANGLE_W'(ang_wide);

    // Q4.12 to Q2.30, one turn of 2*pi at most
    assign a_q30 = $signed({ang_reg[ANGLE_W-1], ang_reg, {Q30_SHIFT{1'b0}}});

    always_comb begin
        priority if (a_q30 > PI_Q30) begin
            red_next = a_q30 - TWO_PI_Q30;
        end else if (a_q30 < NEG_PI_Q30) begin
            red_next = a_q30 + TWO_PI_Q30;
        end else begin
            red_next = a_q30;
        end
    end

    // Fold into the right half plane, negate both results later
    always_comb begin
        fold      = red_reg;
        flip_next = 1'b0;
        priority if (red_reg > HALF_PI_Q30) begin
            fold      = red_reg - PI_Q30;
            flip_next = 1'b1;
        end else if (red_reg < NEG_HALF_PI_Q30) begin
            fold      = red_reg + PI_Q30;
            flip_next = 1'b1;
        end else begin
            fold      = red_reg;
        end
        z_next = Z_W'(fold);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            if (a_rdy) a_valid_reg <= in_valid;
            if (r_rdy) r_valid_reg <= a_valid_reg;
            if (f_rdy) f_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            a_meta_reg <= in_meta;
            ang_reg    <= ang_next;
        end
        if (r_rdy) begin
            r_meta_reg <= a_meta_reg;
            red_reg    <= red_next;
        end
        if (f_rdy) begin
            f_meta_reg <= r_meta_reg;
            z_reg      <= z_next;
            flip_reg   <= flip_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_meta  = f_meta_reg;
    assign out_flip  = flip_reg;
    assign out_z     = z_reg;

endmodule

### src/afvg_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
module afvg_cordic (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  afvg_pkg::meta_t                  in_meta,
    input  logic                             in_flip,
    input  logic signed [afvg_pkg::Z_W-1:0]  in_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output afvg_pkg::meta_t                  out_meta,
    output logic                             out_flip,
    output logic signed [afvg_pkg::TRIG_W-1:0] out_cos,
    output logic signed [afvg_pkg::TRIG_W-1:0] out_sin
);
    import afvg_pkg::*;

    logic                     v_reg    [CORDIC_N];
    logic                     rdy      [CORDIC_N];
    meta_t                    meta_reg [CORDIC_N];
    logic                     flip_reg [CORDIC_N];
    logic signed [TRIG_W-1:0] x_reg    [CORDIC_N];
    logic signed [TRIG_W-1:0] y_reg    [CORDIC_N];
    logic signed [Z_W-1:0]    z_reg    [CORDIC_N];

    for (genvar g = 0; g < CORDIC_N; g++) begin : g_stage
        logic                     src_v;
        meta_t                    src_meta;
        logic                     src_flip;
        logic signed [TRIG_W-1:0] src_x, src_y, x_next, y_next, xs, ys;
        logic signed [Z_W-1:0]    src_z, z_next;

        if (g == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_meta = in_meta;
            assign src_flip = in_flip;
            assign src_x    = GAIN_Q30;
            assign src_y    = '0;
            assign src_z    = in_z;
        end else begin : g_rest
            assign src_v    = v_reg[g-1];
            assign src_meta = meta_reg[g-1];
            assign src_flip = flip_reg[g-1];
            assign src_x    = x_reg[g-1];
            assign src_y    = y_reg[g-1];
            assign src_z    = z_reg[g-1];
        end

        if (g == CORDIC_N - 1) begin : g_tail
            assign rdy[g] = !v_reg[g] || out_ready;
        end else begin : g_body
            assign rdy[g] = !v_reg[g] || rdy[g+1];
        end

        assign xs = src_x >>> g;
        assign ys = src_y >>> g;

        // Rotate toward zero residual angle
        always_comb begin
            if (!src_z[Z_W-1]) begin
                x_next = src_x - ys;
                y_next = src_y + xs;
                z_next = src_z - atan_q30(g);
            end else begin
                x_next = src_x + ys;
                y_next = src_y - xs;
                z_next = src_z + atan_q30(g);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                v_reg[g] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g]) begin
                meta_reg[g] <= src_meta;
                flip_reg[g] <= src_flip;
                x_reg[g]    <= x_next;
                y_reg[g]    <= y_next;
                z_reg[g]    <= z_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[CORDIC_N-1];
    assign out_meta  = meta_reg[CORDIC_N-1];
    assign out_flip  = flip_reg[CORDIC_N-1];
    assign out_cos   = x_reg[CORDIC_N-1];
    assign out_sin   = y_reg[CORDIC_N-1];

endmodule

### src/afvg_scale.sv
// Radius multiply, rounding, center offset, saturation and the output register.
module afvg_scale (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  afvg_pkg::cfg_t                     cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  afvg_pkg::meta_t                    in_meta,
    input  logic                               in_flip,
    input  logic signed [afvg_pkg::TRIG_W-1:0] in_cos,
    input  logic signed [afvg_pkg::TRIG_W-1:0] in_sin,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [afvg_pkg::COORD_WIDTH-1:0] out_pos_x,
    output logic signed [afvg_pkg::COORD_WIDTH-1:0] out_pos_y,
    output logic                               out_index_valid,
    output logic                               out_last
);
    import afvg_pkg::*;

    logic                          m_valid_reg, o_valid_reg;
    logic                          m_rdy, o_rdy;
    meta_t                         m_meta_reg;
    logic signed [PROD_W-1:0]      px_reg, py_reg, px_next, py_next;
    logic signed [TRIG_W-1:0]      cos_f, sin_f;
    logic signed [RADIUS_W:0]      r;
    logic signed [PROD_W-1:0]      rx, ry;
    logic signed [SUM_W-1:0]       sx, sy, cx, cy;
    logic signed [COORD_WIDTH-1:0] pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic                          iv_reg, iv_next, last_reg;

    assign o_rdy    = !o_valid_reg || out_ready;
    assign m_rdy    = !m_valid_reg || o_rdy;
    assign in_ready = m_rdy;

    // Multiply stage: undo the fold, then scale by the radius
    assign cos_f   = in_flip ? -in_cos : in_cos;
    assign sin_f   = in_flip ? -in_sin : in_sin;
    assign r       = $signed({1'b0, cfg.radius});
    assign px_next = r * cos_f;
    assign py_next = r * sin_f;

    // Output stage: round half up to Q1.14 and add the center
    assign rx = px_reg + ROUND_HALF;
    assign ry = py_reg + ROUND_HALF;
    assign cx = SUM_W'($signed(cfg.center_x));
    assign cy = SUM_W'($signed(cfg.center_y));
    assign sx = SUM_W'($signed(rx[PROD_W-1:FRAC_Q30])) + cx;
    assign sy = SUM_W'($signed(ry[PROD_W-1:FRAC_Q30])) + cy;

    always_comb begin
        unique case (m_meta_reg.kind)
            KIND_ARC: begin
                pos_x_next = sat_coord(sx);
                pos_y_next = sat_coord(sy);
                iv_next    = 1'b1;
            end
            KIND_CENTER: begin
                pos_x_next = sat_coord(cx);
                pos_y_next = sat_coord(cy);
                iv_next    = 1'b1;
            end
            default: begin
                pos_x_next = '0;
                pos_y_next = '0;
                iv_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (m_rdy) m_valid_reg <= in_valid;
            if (o_rdy) o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_rdy) begin
            m_meta_reg <= in_meta;
            px_reg     <= px_next;
            py_reg     <= py_next;
        end
        if (o_rdy) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            iv_reg    <= iv_next;
            last_reg  <= m_meta_reg.last;
        end
    end

    assign out_valid       = o_valid_reg;
    assign out_pos_x       = pos_x_reg;
    assign out_pos_y       = pos_y_reg;
    assign out_index_valid = iv_reg;
    assign out_last        = last_reg;

endmodule

### src/arc_fan_vertex_generator_top.sv
// Top level of the arc fan vertex generator: configuration registers and pipeline chain.
//
// Usage:
//   Send one fan vertex index per transfer on the s_ channel (s_tdata[8:0]).
//   Index 0 returns the configured center; index k in 1..sides+1 returns the
//   arc point k-1, center + radius * (cos, sin) of the interpolated angle.
//   Each result leaves on the m_ channel: m_tdata holds pos_x then pos_y,
//   m_tuser flags an index in range, m_tlast marks the final arc point.
//   Write configuration through cfg_we/cfg_addr/cfg_wdata only while no
//   item is in flight; a write to an unknown index is dropped.
// Pipeline:
//   An item passes 2 decode/multiply stages, 5 divider stages, 3 angle
//   stages, 14 CORDIC stages and 2 scaling stages, each a register slice.
//   One item enters per cycle unless m_tready back-pressure stalls it.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and loads the
//   default arc: 100 sides, radius 0.6, angles 0 to 2*pi, center at origin.
// Backpressure:
//   When m_tready is low each stage holds its item; empty stages keep filling,
//   so s_tready stays high until the whole pipeline is full.
module arc_fan_vertex_generator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [afvg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [afvg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // vertex index stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [afvg_pkg::IN_TDATA_W-1:0]    s_tdata,   // [8:0] vertex_index
    // vertex stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [afvg_pkg::OUT_TDATA_W-1:0]   m_tdata,   // pos_x, then pos_y
    output logic                               m_tuser,   // index_valid
    output logic                               m_tlast    // last_vertex
);
    import afvg_pkg::*;

    localparam logic [SIDES_W-1:0]  RST_SIDES  = SIDES_W'(100);
    localparam logic [RADIUS_W-1:0] RST_RADIUS = RADIUS_W'(9830);
    localparam logic [ANGLE_W-1:0]  RST_START  = '0;
    localparam logic [ANGLE_W-1:0]  RST_END    = ANGLE_W'(25736);
    localparam logic [CENTER_W-1:0] RST_CENTER = '0;

    // Configuration registers
    logic [SIDES_W-1:0]  sides_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [ANGLE_W-1:0]  start_reg, end_reg;
    logic [CENTER_W-1:0] cx_reg, cy_reg;

    cfg_t               cfg;
    logic [SIDES_W-1:0] sides_eff;
    logic [SIDES_W-1:0] divisor;

    // Inter-stage streams
    logic                     fr_valid, fr_ready;
    meta_t                    fr_meta;
    logic                     fr_neg;
    logic [NUM_W-1:0]         fr_mag;
    logic                     dv_valid, dv_ready;
    meta_t                    dv_meta;
    logic                     dv_neg;
    logic [NUM_W-1:0]         dv_quot;
    logic                     an_valid, an_ready;
    meta_t                    an_meta;
    logic                     an_flip;
    logic signed [Z_W-1:0]    an_z;
    logic                     co_valid, co_ready;
    meta_t                    co_meta;
    logic                     co_flip;
    logic signed [TRIG_W-1:0] co_cos, co_sin;
    logic signed [COORD_WIDTH-1:0] pos_x, pos_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sides_reg  <= RST_SIDES;
            radius_reg <= RST_RADIUS;
            start_reg  <= RST_START;
            end_reg    <= RST_END;
            cx_reg     <= RST_CENTER;
            cy_reg     <= RST_CENTER;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ARC_SIDES:   sides_reg  <= cfg_wdata[SIDES_W-1:0];
                REG_RADIUS:      radius_reg <= cfg_wdata[RADIUS_W-1:0];
                REG_START_ANGLE: start_reg  <= cfg_wdata[ANGLE_W-1:0];
                REG_END_ANGLE:   end_reg    <= cfg_wdata[ANGLE_W-1:0];
                REG_CENTER_X:    cx_reg     <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:    cy_reg     <= cfg_wdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.radius      = radius_reg;
    assign cfg.start_angle = $signed(start_reg);
    assign cfg.end_angle   = $signed(end_reg);
    assign cfg.center_x    = $signed(cx_reg);
    assign cfg.center_y    = $signed(cy_reg);

    // Clamp the segment count; zero sides divide by one
    assign sides_eff = (int'(sides_reg) > MAX_SIDES) ? SIDES_W'(MAX_SIDES) : sides_reg;
    assign divisor   = (sides_eff == '0) ? SIDES_W'(1) : sides_eff;

    afvg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .sides     (sides_eff),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_index  (s_tdata[INDEX_W-1:0]),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_meta  (fr_meta),
        .out_neg   (fr_neg),
        .out_mag   (fr_mag)
    );

    afvg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .divisor   (divisor),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_meta   (fr_meta),
        .in_neg    (fr_neg),
        .in_mag    (fr_mag),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_meta  (dv_meta),
        .out_neg   (dv_neg),
        .out_quot  (dv_quot)
    );

    afvg_angle u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_meta   (dv_meta),
        .in_neg    (dv_neg),
        .in_quot   (dv_quot),
        .out_valid (an_valid),
        .out_ready (an_ready),
        .out_meta  (an_meta),
        .out_flip  (an_flip),
        .out_z     (an_z)
    );

    afvg_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (an_valid),
        .in_ready  (an_ready),
        .in_meta   (an_meta),
        .in_flip   (an_flip),
        .in_z      (an_z),
        .out_valid (co_valid),
        .out_ready (co_ready),
        .out_meta  (co_meta),
        .out_flip  (co_flip),
        .out_cos   (co_cos),
        .out_sin   (co_sin)
    );

    afvg_scale u_scale (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .in_valid        (co_valid),
        .in_ready        (co_ready),
        .in_meta         (co_meta),
        .in_flip         (co_flip),
        .in_cos          (co_cos),
        .in_sin          (co_sin),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_pos_x       (pos_x),
        .out_pos_y       (pos_y),
        .out_index_valid (m_tuser),
        .out_last        (m_tlast)
    );

    // Pack pos_x low, pos_y above it, zero pad to whole bytes
    assign m_tdata = OUT_TDATA_W'({pos_y, pos_x});

endmodule

### bench/arc_fan_vertex_checker.sv
// Checker for the arc fan vertex generator: tracks the registers, predicts each vertex, compares.
module arc_fan_vertex_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [afvg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [afvg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [afvg_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [afvg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 m_tlast,
    output int                                   mismatches,
    output int                                   outstanding,
    output int                                   checked,
    output int                                   fan_ends,
    output int                                   out_of_range
);

    localparam int CW         = afvg_pkg::COORD_WIDTH;
    localparam int ROT_STAGES = (afvg_pkg::CORDIC_STAGES < 24) ? afvg_pkg::CORDIC_STAGES : 24;

    // Angles in Q2.30
    localparam longint HALF_TURN    = 64'sd3373259426;
    localparam longint QUARTER_TURN = 64'sd1686629713;
    localparam longint FULL_TURN    = 64'sd6746518852;
    localparam longint CORDIC_GAIN  = 64'sd652032875;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic                 in_range;
        logic                 fan_end;
    } vertex_t;

    longint atan_tab [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    // Shadow copy of the arc registers
    logic        [afvg_pkg::SIDES_W-1:0]  arc_sides = 8'd100;
    logic        [afvg_pkg::RADIUS_W-1:0] radius    = 15'd9830;
    logic signed [afvg_pkg::ANGLE_W-1:0]  start_ang = 16'sd0;
    logic signed [afvg_pkg::ANGLE_W-1:0]  end_ang   = 16'sd25736;
    logic signed [afvg_pkg::CENTER_W-1:0] center_x  = 16'sd0;
    logic signed [afvg_pkg::CENTER_W-1:0] center_y  = 16'sd0;

    vertex_t pending_vertices [$];
    int      n_bad  = 0;
    int      n_seen = 0;
    int      n_ends = 0;
    int      n_oor  = 0;

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return CW'(v);
    endfunction

    // Rotation-mode CORDIC on a Q2.30 angle, folded into the right half plane first
    function automatic void rotate_unit(input longint a, output longint cos_v,
                                        output longint sin_v);
        longint x;
        longint y;
        longint t;
        bit     mirror;
        int     i;
        x = CORDIC_GAIN;
        y = 0;
        mirror = 1'b0;
        while (a > HALF_TURN) a -= FULL_TURN;
        while (a < -HALF_TURN) a += FULL_TURN;
        if (a > QUARTER_TURN) begin
            a -= HALF_TURN;
            mirror = 1'b1;
        end else if (a < -QUARTER_TURN) begin
            a += HALF_TURN;
            mirror = 1'b1;
        end
        for (i = 0; i < ROT_STAGES; i++) begin
            if (a >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                a -= atan_tab[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                a += atan_tab[i];
            end
            x = t;
        end
        cos_v = mirror ? -x : x;
        sin_v = mirror ? -y : y;
    endfunction

    function automatic vertex_t predict_vertex(input logic [afvg_pkg::INDEX_W-1:0] idx);
        vertex_t v;
        longint  k;
        longint  n_seg;
        longint  divisor;
        longint  a0;
        longint  span;
        longint  ang;
        longint  c;
        longint  s;
        longint  r;
        longint  half;
        k = idx;
        n_seg = (arc_sides > afvg_pkg::MAX_SIDES) ? afvg_pkg::MAX_SIDES : arc_sides;
        divisor = (n_seg == 0) ? 1 : n_seg;
        v = '0;
        if (k == 0) begin
            v.pos_x = clamp_coord(longint'(center_x));
            v.pos_y = clamp_coord(longint'(center_y));
            v.in_range = 1'b1;
        end else if (k <= n_seg + 1) begin
            a0 = longint'(start_ang);
            span = longint'(end_ang) - a0;
            // signed divide truncates toward zero
            ang = a0 + (span * (k - 1)) / divisor;
            rotate_unit(ang * 262144, c, s);
            r = radius;
            half = longint'(1) <<< 29;
            v.pos_x = clamp_coord(longint'(center_x) + ((r * c + half) >>> 30));
            v.pos_y = clamp_coord(longint'(center_y) + ((r * s + half) >>> 30));
            v.in_range = 1'b1;
            v.fan_end = (k == n_seg + 1);
        end
        return v;
    endfunction

    always @(posedge aclk) begin : watch
        vertex_t got;
        vertex_t want;
        vertex_t fresh;
        if (!aresetn) begin
            arc_sides = 8'd100;
            radius    = 15'd9830;
            start_ang = 16'sd0;
            end_ang   = 16'sd25736;
            center_x  = 16'sd0;
            center_y  = 16'sd0;
            pending_vertices.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    afvg_pkg::REG_ARC_SIDES:   arc_sides = cfg_wdata[afvg_pkg::SIDES_W-1:0];
                    afvg_pkg::REG_RADIUS:      radius    = cfg_wdata[afvg_pkg::RADIUS_W-1:0];
                    afvg_pkg::REG_START_ANGLE: start_ang = cfg_wdata;
                    afvg_pkg::REG_END_ANGLE:   end_ang   = cfg_wdata;
                    afvg_pkg::REG_CENTER_X:    center_x  = cfg_wdata;
                    afvg_pkg::REG_CENTER_Y:    center_y  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                fresh = predict_vertex(s_tdata[afvg_pkg::INDEX_W-1:0]);
                pending_vertices.insert(pending_vertices.size(), fresh);
            end
            if (m_tvalid && m_tready) begin
                got.pos_x    = m_tdata[CW-1:0];
                got.pos_y    = m_tdata[2*CW-1:CW];
                got.in_range = m_tuser;
                got.fan_end  = m_tlast;
                if (pending_vertices.size() == 0) begin
                    n_bad++;
                    $display("%0t: unexpected vertex x=%0d y=%0d valid=%0b last=%0b", $time,
                             got.pos_x, got.pos_y, got.in_range, got.fan_end);
                end else begin
                    want = pending_vertices.pop_front();
                    n_seen++;
                    if (want.fan_end) n_ends++;
                    if (!want.in_range) n_oor++;
                    if (got !== want) begin
                        n_bad++;
                        $display("%0t: vertex mismatch: expected x=%0d y=%0d valid=%0b last=%0b",
                                 $time, want.pos_x, want.pos_y, want.in_range, want.fan_end);
                        $display("%0t:                  actual x=%0d y=%0d valid=%0b last=%0b",
                                 $time, got.pos_x, got.pos_y, got.in_range, got.fan_end);
                    end
                end
            end
        end
        mismatches   <= n_bad;
        outstanding  <= pending_vertices.size();
        checked      <= n_seen;
        fan_ends     <= n_ends;
        out_of_range <= n_oor;
    end

endmodule

### bench/tb_arc_fan_vertex_generator_top.sv
// Testbench top for the arc fan vertex generator: clock, reset, stimulus and verdict.
module tb_arc_fan_vertex_generator_top;

    // Pipeline latency from an input transfer to m_tvalid
    localparam int LATENCY          = 26;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_ITEMS     = 1500;
    localparam int PHASE_ITEMS      = 120;
    localparam int LONG_HOLD_CYCLES = 300;

    // Register indexes the block does not decode; writes there must be dropped
    localparam logic [afvg_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [afvg_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 cfg_we;
    logic [afvg_pkg::CFG_ADDR_W-1:0]      cfg_addr;
    logic [afvg_pkg::CFG_DATA_W-1:0]      cfg_wdata;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [afvg_pkg::IN_TDATA_W-1:0]      s_tdata;    // [8:0] vertex_index
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [afvg_pkg::OUT_TDATA_W-1:0]     m_tdata;    // [15:0] pos_x, [31:16] pos_y
    logic                                 m_tuser;    // index_valid
    logic                                 m_tlast;    // last_vertex

    int mismatches;
    int outstanding;
    int checked;
    int fan_ends;
    int out_of_range;

    // Flags shared by the sender and receiver processes, plus the sender's counts
    bit idle_on   = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int sent      = 0;
    int settings  = 0;

    arc_fan_vertex_generator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    arc_fan_vertex_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .fan_ends     (fan_ends),
        .out_of_range (out_of_range)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end the run if it has not finished within the cycle budget.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Idle length in cycles, drawn at random; one draw in twenty is a long stretch.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // A 16-bit register value: often one of the extremes or zero, else random.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Result sink: toggle m_tready at random while idling is on, hold it high otherwise,
    // and drop it for a long counted stretch when the stimulus asks for back-pressure.
    initial begin : result_sink
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!idle_on || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end
        end
    end

    // Offer one index and hold it until the transfer. Valid stays high afterwards
    // unless a random gap follows, so back-to-back items never see a low pulse.
    task automatic send_vertex(input logic [afvg_pkg::INDEX_W-1:0] idx);
        s_tdata  <= afvg_pkg::IN_TDATA_W'(idx);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted vertex has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Write all six arc registers, optionally followed by writes to undecoded indexes
    // that must leave them untouched.
    task automatic program_arc(input logic [7:0] sides, input logic [14:0] rad,
                               input logic [15:0] a_from, input logic [15:0] a_to,
                               input logic [15:0] org_x, input logic [15:0] org_y,
                               input bit poke_spare);
        logic [afvg_pkg::CFG_ADDR_W-1:0] addr [0:7];
        logic [afvg_pkg::CFG_DATA_W-1:0] data [0:7];
        int n;
        int i;
        addr[0] = afvg_pkg::REG_ARC_SIDES;   data[0] = 16'(sides);
        addr[1] = afvg_pkg::REG_RADIUS;      data[1] = 16'(rad);
        addr[2] = afvg_pkg::REG_START_ANGLE; data[2] = a_from;
        addr[3] = afvg_pkg::REG_END_ANGLE;   data[3] = a_to;
        addr[4] = afvg_pkg::REG_CENTER_X;    data[4] = org_x;
        addr[5] = afvg_pkg::REG_CENTER_Y;    data[5] = org_y;
        addr[6] = REG_SPARE_A;               data[6] = 16'($urandom);
        addr[7] = REG_SPARE_B;               data[7] = 16'($urandom);
        n = poke_spare ? 8 : 6;
        for (i = 0; i < n; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addr[i];
            cfg_wdata <= data[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        logic [7:0]  sides;
        logic [14:0] rad;
        int          fan_top;
        int          phase;
        int          phase_start;
        int          first;
        int          count;
        int          i;
        bit          paused;

        // Known values on every input from time zero; reset is asserted, then released.
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: the default arc after reset - center, first points, fan end,
        // the first index past it and the largest index.
        send_vertex(9'd0);
        send_vertex(9'd1);
        send_vertex(9'd2);
        send_vertex(9'd51);
        send_vertex(9'd100);
        send_vertex(9'd101);
        send_vertex(9'd102);
        send_vertex(9'd256);
        send_vertex(9'd511);
        drain();

        // Single segment, full radius, full angle sweep, center at the corners of
        // the range so the start point's y saturates; undecoded writes must be dropped.
        program_arc(8'd1, 15'd32767, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        send_vertex(9'd0);
        send_vertex(9'd1);
        send_vertex(9'd2);
        send_vertex(9'd3);
        drain();

        // Zero sides: index 1 is the start point and already the fan end.
        program_arc(8'd0, 15'd16384, 16'd6434, 16'hE6DE, 16'hFF9C, 16'd100, 1'b0);
        send_vertex(9'd0);
        send_vertex(9'd1);
        send_vertex(9'd2);
        drain();

        // Most sides, zero radius, reversed extreme angles.
        program_arc(8'd255, 15'd0, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 1'b0);
        send_vertex(9'd256);
        send_vertex(9'd257);
        send_vertex(9'd1);
        drain();

        // Random phases: each one a fresh arc, mostly whole fans swept in order,
        // with runs of arbitrary indexes mixed in as noise.
        phase = 0;
        first = sent;
        while (sent - first < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       sides = 8'd0;
                1:       sides = 8'd1;
                2:       sides = 8'd255;
                3, 4:    sides = 8'($urandom_range(2, 255));
                default: sides = 8'($urandom_range(2, 24));
            endcase
            case ($urandom_range(0, 3))
                0:       rad = 15'd0;
                1:       rad = 15'd32767;
                default: rad = 15'($urandom_range(0, 32767));
            endcase
            program_arc(sides, rad, pick_word(), pick_word(), pick_word(), pick_word(),
                        phase % 5 == 4);

            // Phase 1 floods the block while the sink holds off; phase 2 runs without
            // any idling; the rest idle on both sides.
            idle_on = (phase != 1 && phase != 2);
            if (phase == 1) hold_req = 1'b1;
            paused = 1'b0;
            fan_top = (sides == 0) ? 1 : int'(sides) + 1;
            phase_start = sent;

            while (sent - phase_start < PHASE_ITEMS) begin
                // Once, in phase 3, let everything come back before going on.
                if (phase == 3 && !paused && sent - phase_start >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0, 1: begin
                        count = $urandom_range(1, 6);
                        for (i = 0; i < count; i++) send_vertex(9'($urandom_range(0, 511)));
                    end
                    2: begin
                        for (i = $urandom_range(0, fan_top); i <= fan_top; i++)
                            send_vertex(9'(i));
                    end
                    default: begin
                        for (i = 0; i <= fan_top; i++) send_vertex(9'(i));
                    end
                endcase
            end
            drain();
            phase++;
        end

        // Let any stray result show up before the verdict.
        repeat (LATENCY + 10) @(posedge aclk);

        $display("Summary: %0d vertex indexes sent under %0d register settings.", sent,
                 settings + 1);
        $display("Summary: %0d vertices checked, %0d fan ends, %0d out of range.", checked,
                 fan_ends, out_of_range);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
